[rtl/aps_pkg.sv]
// Shared types, widths and codes for the aging priority scheduler.
package aps_pkg;

	localparam int ID_W     = 8;
	localparam int PRIO_W   = 6;
	localparam int DYN_W    = 8;
	localparam int RC_W     = 5;
	localparam int STEP_W   = 6;

	localparam int S_TDATA_W = 16;
	localparam int S_TUSER_W = 1;
	localparam int M_TDATA_W = 24;
	localparam int M_TUSER_W = 2;

	// result tdata layout
	localparam int M_ID_LSB   = 0;
	localparam int M_PRIO_LSB = M_ID_LSB + ID_W;
	localparam int M_RC_LSB   = M_PRIO_LSB + PRIO_W;
	localparam int M_PAD_W    = M_TDATA_W - M_RC_LSB - RC_W;

	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	// register word index (paddr[2])
	localparam logic REG_AGING_STEP = 1'b0;
	localparam logic signed [STEP_W-1:0] AGING_STEP_RST = -6'sd1;

	localparam logic FUNC_ENQ  = 1'b0;
	localparam logic FUNC_PICK = 1'b1;

	typedef enum logic [M_TUSER_W-1:0] {
		STATUS_OK    = 2'd0,
		STATUS_EMPTY = 2'd1,
		STATUS_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic [ID_W-1:0]          id;
		logic signed [PRIO_W-1:0] stat;
		logic signed [DYN_W-1:0]  dyn;
	} slot_t;

	localparam int SLOT_W = $bits(slot_t);

	typedef struct packed {
		logic                    less;
		logic signed [DYN_W-1:0] aged;
	} alu_res_t;

endpackage

[rtl/aps_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module aps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/aps_alu.sv]
// Shared compare and saturating aging adder for the slot sweeps.
module aps_alu (
	input  logic signed [aps_pkg::DYN_W-1:0]  a_dyn,
	input  logic signed [aps_pkg::DYN_W-1:0]  b_dyn,
	input  logic signed [aps_pkg::STEP_W-1:0] step,
	output aps_pkg::alu_res_t                 res
);
	import aps_pkg::*;

	localparam logic signed [DYN_W:0] SUM_MAX = (DYN_W+1)'(2**(DYN_W-1) - 1);
	localparam logic signed [DYN_W:0] SUM_MIN = -(DYN_W+1)'(2**(DYN_W-1));

	logic signed [DYN_W:0] sum;

	assign sum = {a_dyn[DYN_W-1], a_dyn} +
		{{(DYN_W+1-STEP_W){step[STEP_W-1]}}, step};

	always_comb begin
		res.less = (a_dyn < b_dyn);
		priority if (sum > SUM_MAX) begin
			res.aged = SUM_MAX[DYN_W-1:0];
		end else if (sum < SUM_MIN) begin
			res.aged = SUM_MIN[DYN_W-1:0];
		end else begin
			res.aged = sum[DYN_W-1:0];
		end
	end

endmodule

[rtl/aps_cfg.sv]
// APB register block holding the aging step.
module aps_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [aps_pkg::APB_AW-1:0]      paddr,
	input  logic [aps_pkg::APB_DW-1:0]      pwdata,
	output logic [aps_pkg::APB_DW-1:0]      prdata,
	output logic                            pready,
	output logic signed [aps_pkg::STEP_W-1:0] aging_step
);
	import aps_pkg::*;

	logic signed [STEP_W-1:0] step_q;
	logic                     wr_step;

	assign pready  = 1'b1;
	assign wr_step = psel & penable & pwrite & (paddr[2] == REG_AGING_STEP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= AGING_STEP_RST;
		end else if (wr_step) begin
			step_q <= pwdata[STEP_W-1:0];
		end
	end

	always_comb begin
		if (paddr[2] == REG_AGING_STEP) begin
			prdata = {{(APB_DW-STEP_W){step_q[STEP_W-1]}}, step_q};
		end else begin
			prdata = '0;
		end
	end

	assign aging_step = step_q;

endmodule

[rtl/aging_priority_scheduler_unit.sv]
// Aging priority scheduler: ready table in a slot RAM, swept by a small sequencer.
//
//  channel   dir  handshake          payload
//  s_axis    in   tvalid/tready      tdata: task_id[7:0] prio[13:8]; tuser: func[0]
//  m_axis    out  tvalid/tready      tdata: chosen_id[7:0] chosen_prio[13:8]
//                                           ready_count[18:14]; tuser: status[1:0]
//  apb       in   psel/penable       aging_step at byte address 0
//
// Enqueue, and pick on an empty table: the sequencer goes straight to the response state,
// which loads the output register. Other picks sweep the slot RAM's single read port once
// to find the winner and once more to close the gap and age the others.
// Reset clears the entry count and sets the aging step to -1; the RAM is not cleared.
// s_axis_tready is high only when idle; a finished result waits in the output register
// and the sequencer holds until that register is free.
module aging_priority_scheduler_unit #(
	parameter int NUM_SLOTS = 16,
	parameter int MAX_PRIO  = 20
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [aps_pkg::S_TDATA_W-1:0]     s_axis_tdata,  // task_id, prio, pad
	input  logic [aps_pkg::S_TUSER_W-1:0]     s_axis_tuser,  // func
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [aps_pkg::M_TDATA_W-1:0]     m_axis_tdata,  // chosen_id, chosen_prio, ready_count, pad
	output logic [aps_pkg::M_TUSER_W-1:0]     m_axis_tuser,  // status
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [aps_pkg::APB_AW-1:0]        paddr,
	input  logic [aps_pkg::APB_DW-1:0]        pwdata,
	output logic [aps_pkg::APB_DW-1:0]        prdata,
	output logic                              pready
);
	import aps_pkg::*;

	localparam int ADDR_W = $clog2(NUM_SLOTS);
	localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(NUM_SLOTS);
	localparam logic signed [DYN_W-1:0] PRIO_HI = DYN_W'(MAX_PRIO);
	localparam logic signed [DYN_W-1:0] PRIO_LO = DYN_W'(-MAX_PRIO);

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_COMPACT, ST_RESP} state_t;

	state_t                   state_q;
	logic [CNT_W-1:0]         count_q;
	logic [CNT_W-1:0]         rd_ptr_q;
	logic [ADDR_W-1:0]        wr_ptr_q;
	logic                     rd_valid_s1;
	logic [ADDR_W-1:0]        rd_idx_s1;
	logic [ADDR_W-1:0]        best_idx_q;
	logic signed [DYN_W-1:0]  best_dyn_q;
	logic [ID_W-1:0]          best_id_q;
	logic signed [PRIO_W-1:0] best_stat_q;
	status_t                  res_status_q;
	logic [ID_W-1:0]          res_id_q;
	logic signed [PRIO_W-1:0] res_prio_q;
	logic                     m_valid_q;
	status_t                  m_status_q;
	logic [ID_W-1:0]          m_id_q;
	logic signed [PRIO_W-1:0] m_prio_q;
	logic [RC_W-1:0]          m_rc_q;

	logic signed [STEP_W-1:0] aging_step;
	logic                     in_func;
	logic [ID_W-1:0]          in_id;
	logic signed [PRIO_W-1:0] in_prio;
	logic signed [DYN_W-1:0]  in_prio_x;
	logic signed [PRIO_W-1:0] enq_stat;
	slot_t                    enq_entry;
	slot_t                    rd_entry;
	slot_t                    keep_entry;
	alu_res_t                 alu_res;
	logic                     accept;
	logic                     is_full;
	logic                     enq_wr;
	logic                     issue;
	logic                     last_s1;
	logic                     take;
	logic                     keep;
	logic                     out_load;
	logic                     ram_we;
	logic [ADDR_W-1:0]        ram_waddr;
	logic [SLOT_W-1:0]        ram_wdata;
	logic [SLOT_W-1:0]        ram_rdata;

	aps_cfg u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.aging_step (aging_step)
	);

	assign in_func   = s_axis_tuser[0];
	assign in_id     = s_axis_tdata[ID_W-1:0];
	assign in_prio   = s_axis_tdata[ID_W +: PRIO_W];
	assign in_prio_x = {{(DYN_W-PRIO_W){in_prio[PRIO_W-1]}}, in_prio};
	// out-of-range priority enters as zero
	assign enq_stat  = (in_prio_x >= PRIO_LO && in_prio_x <= PRIO_HI) ? in_prio : '0;

	assign enq_entry.id   = in_id;
	assign enq_entry.stat = enq_stat;
	assign enq_entry.dyn  = {{(DYN_W-PRIO_W){enq_stat[PRIO_W-1]}}, enq_stat};

	assign accept  = s_axis_tvalid & s_axis_tready;
	assign is_full = (count_q == FULL_CNT);
	assign enq_wr  = accept && (in_func == FUNC_ENQ) && !is_full;

	assign issue   = ((state_q == ST_SCAN) || (state_q == ST_COMPACT)) && (rd_ptr_q < count_q);
	assign last_s1 = rd_valid_s1 && (rd_ptr_q == count_q);
	assign rd_entry = slot_t'(ram_rdata);

	aps_alu u_alu (
		.a_dyn (rd_entry.dyn),
		.b_dyn (best_dyn_q),
		.step  (aging_step),
		.res   (alu_res)
	);

	// strict less keeps the earliest entry on a tie
	assign take = (state_q == ST_SCAN) && rd_valid_s1 && ((rd_idx_s1 == '0) || alu_res.less);
	assign keep = (state_q == ST_COMPACT) && rd_valid_s1 && (rd_idx_s1 != best_idx_q);

	assign keep_entry.id   = rd_entry.id;
	assign keep_entry.stat = rd_entry.stat;
	assign keep_entry.dyn  = alu_res.aged;

	// compaction writes trail the read pointer, so no same-address clash
	assign ram_we    = enq_wr || keep;
	assign ram_waddr = keep ? wr_ptr_q : count_q[ADDR_W-1:0];
	assign ram_wdata = keep ? keep_entry : enq_entry;

	aps_ram #(
		.WIDTH (SLOT_W),
		.DEPTH (NUM_SLOTS)
	) u_slots (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (issue),
		.raddr (rd_ptr_q[ADDR_W-1:0]),
		.rdata (ram_rdata)
	);

	assign out_load = (state_q == ST_RESP) && (!m_valid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			rd_ptr_q     <= '0;
			wr_ptr_q     <= '0;
			rd_valid_s1  <= 1'b0;
			rd_idx_s1    <= '0;
			best_idx_q   <= '0;
			best_dyn_q   <= '0;
			best_id_q    <= '0;
			best_stat_q  <= '0;
			res_status_q <= STATUS_OK;
			res_id_q     <= '0;
			res_prio_q   <= '0;
			m_valid_q    <= 1'b0;
			m_status_q   <= STATUS_OK;
			m_id_q       <= '0;
			m_prio_q     <= '0;
			m_rc_q       <= '0;
		end else begin
			rd_valid_s1 <= issue;
			rd_idx_s1   <= rd_ptr_q[ADDR_W-1:0];
			if (issue) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (take) begin
				best_idx_q  <= rd_idx_s1;
				best_dyn_q  <= rd_entry.dyn;
				best_id_q   <= rd_entry.id;
				best_stat_q <= rd_entry.stat;
			end
			if (keep) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end

			if (out_load) begin
				m_valid_q  <= 1'b1;
				m_status_q <= res_status_q;
				m_id_q     <= res_id_q;
				m_prio_q   <= res_prio_q;
				m_rc_q     <= RC_W'(count_q);
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						res_id_q   <= '0;
						res_prio_q <= '0;
						rd_ptr_q   <= '0;
						wr_ptr_q   <= '0;
						if (in_func == FUNC_ENQ) begin
							state_q <= ST_RESP;
							if (is_full) begin
								res_status_q <= STATUS_FULL;
							end else begin
								res_status_q <= STATUS_OK;
								count_q      <= count_q + 1'b1;
							end
						end else if (count_q == '0) begin
							res_status_q <= STATUS_EMPTY;
							state_q      <= ST_RESP;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (last_s1) begin
						rd_ptr_q <= '0;
						wr_ptr_q <= '0;
						state_q  <= ST_COMPACT;
					end
				end
				ST_COMPACT: begin
					if (last_s1) begin
						count_q      <= count_q - 1'b1;
						res_status_q <= STATUS_OK;
						res_id_q     <= best_id_q;
						res_prio_q   <= best_stat_q;
						state_q      <= ST_RESP;
					end
				end
				ST_RESP: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = m_status_q;
	assign m_axis_tdata  = {{M_PAD_W{1'b0}}, m_rc_q, m_prio_q, m_id_q};

endmodule

[rtl/aps_chk.sv]
// Port-level checker for the aging priority scheduler, bound to the top level.
module aps_chk #(
	parameter int NUM_SLOTS = 16
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_axis_tvalid,
	input logic                          s_axis_tready,
	input logic                          m_axis_tvalid,
	input logic                          m_axis_tready,
	input logic [aps_pkg::M_TDATA_W-1:0] m_axis_tdata,
	input logic [aps_pkg::M_TUSER_W-1:0] m_axis_tuser
);
	import aps_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken again before the transaction finished");

	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == STATUS_EMPTY) |->
			(m_axis_tdata[M_RC_LSB +: RC_W] == '0) && (m_axis_tdata[M_RC_LSB-1:0] == '0))
		else $error("empty pick reported entries or a task");

	a_full_result: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == STATUS_FULL) |->
			(m_axis_tdata[M_RC_LSB +: RC_W] == RC_W'(NUM_SLOTS)) &&
			(m_axis_tdata[M_RC_LSB-1:0] == '0))
		else $error("full enqueue reported wrong count or a task");

endmodule

bind aging_priority_scheduler_unit aps_chk #(.NUM_SLOTS(NUM_SLOTS)) u_aps_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
